// File: sv/arl_pkg.sv
`default_nettype none

package arl_pkg;

  localparam int TABLE_ENTRIES = 4096;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int ADDR_W        = 64;
  localparam int CODE_W        = 16;
  localparam int MATCH_W       = 12;

  typedef struct packed {
    logic [ADDR_W-1:0] start_high;
    logic [ADDR_W-1:0] start_low;
    logic [ADDR_W-1:0] end_high;
    logic [ADDR_W-1:0] end_low;
    logic [CODE_W-1:0] code;
  } entry_t;

  // Result of testing the search key against one stored range.
  typedef struct packed {
    logic lt_start;
    logic gt_end;
  } cmp_t;

endpackage

`default_nettype wire

// File: sv/arl_item_if.sv
`default_nettype none

interface arl_item_if;
  import arl_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [ADDR_W-1:0] addr_high;
  logic [ADDR_W-1:0] addr_low;
  logic [ADDR_W-1:0] range_end_high;
  logic [ADDR_W-1:0] range_end_low;
  logic [CODE_W-1:0] country_code;

  modport source (
    output valid, action, addr_high, addr_low, range_end_high, range_end_low, country_code,
    input  ready
  );

  modport sink (
    input  valid, action, addr_high, addr_low, range_end_high, range_end_low, country_code,
    output ready
  );

endinterface

`default_nettype wire

// File: sv/arl_result_if.sv
`default_nettype none

interface arl_result_if;
  import arl_pkg::*;

  logic               valid;
  logic               ready;
  logic               found;
  logic [CODE_W-1:0]  result_country;
  logic [MATCH_W-1:0] match_index;

  modport source (
    output valid, found, result_country, match_index,
    input  ready
  );

  modport sink (
    input  valid, found, result_country, match_index,
    output ready
  );

endinterface

`default_nettype wire

// File: sv/address_range_lookup.sv
`default_nettype none

// Address range lookup over a table of 128-bit inclusive ranges.
//
// The item channel carries two kinds of word. An append word (action 0)
// stores its range and country code at the next free table position and
// produces no result; appends to a full table are dropped. A lookup word
// (action 1) produces exactly one word on the result channel: found, the
// country code and the table position, or all zeros on a miss.
//
// A lookup reads the table once per cycle: the first entry, the last entry,
// then up to log2(entries) + 1 bisection probes, log2 rounded up. The result
// word is loaded into the output register from the finish state, and item
// ready returns in the same cycle as the result word appears, so a lookup
// holds the item side until it is done; the table has a single read port.
// Item ready is low meanwhile.
//
// The result sits in an output register until taken. A stalled receiver
// holds that word; an append can still be accepted meanwhile, and a new
// lookup runs to its end and then waits until the register frees up.
// Reset empties the table and the output register.
module address_range_lookup (
  input wire logic    clk,
  input wire logic    rst,
  arl_item_if.sink    item,
  arl_result_if.source result
);
  import arl_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_FIRST  = 5'b00010,
    S_LAST   = 5'b00100,
    S_PROBE  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  function automatic logic [IDX_W-1:0] mid_of(input logic [IDX_W-1:0] a,
                                              input logic [IDX_W-1:0] b);
    mid_of = a + ((b - a) >> 1);
  endfunction

  state_t            state, state_next;
  logic [CNT_W-1:0]  cnt;
  logic [ADDR_W-1:0] key_high, key_low;
  logic [IDX_W-1:0]  lo, lo_next, hi, hi_next, idx, idx_next;
  logic              res_found, res_found_next;
  logic [CODE_W-1:0] res_code, res_code_next;
  logic [IDX_W-1:0]  res_idx, res_idx_next;
  logic              out_valid;
  logic              out_found;
  logic [CODE_W-1:0] out_code;
  logic [IDX_W-1:0]  out_idx;
  logic              out_load;

  logic              accept, we, hit;
  logic [IDX_W-1:0]  raddr, last_idx, probe_lo, probe_hi, probe_mid;
  entry_t            wdata, rd_entry;
  cmp_t              cmp;

  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;
  assign we         = accept && !item.action && (cnt < CNT_W'(TABLE_ENTRIES));

  assign wdata.start_high = item.addr_high;
  assign wdata.start_low  = item.addr_low;
  assign wdata.end_high   = item.range_end_high;
  assign wdata.end_low    = item.range_end_low;
  assign wdata.code       = item.country_code;

  arl_table u_table (
    .clk   (clk),
    .we    (we),
    .waddr (cnt[IDX_W-1:0]),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_entry)
  );

  arl_cmp u_cmp (
    .key_high (key_high),
    .key_low  (key_low),
    .entry    (rd_entry),
    .cmp      (cmp)
  );

  assign hit       = !cmp.lt_start && !cmp.gt_end;
  assign last_idx  = IDX_W'(cnt - CNT_W'(1));
  // A key below the probed range pulls the upper bound down, else the lower bound up.
  assign probe_lo  = cmp.lt_start ? lo : idx;
  assign probe_hi  = cmp.lt_start ? idx : hi;
  assign probe_mid = mid_of(probe_lo, probe_hi);
  assign out_load  = (state == S_FINISH) && (!out_valid || result.ready);

  always_comb begin
    state_next     = state;
    lo_next        = lo;
    hi_next        = hi;
    idx_next       = idx;
    res_found_next = res_found;
    res_code_next  = res_code;
    res_idx_next   = res_idx;
    raddr          = '0;
    case (state)
      S_IDLE: begin
        if (accept && item.action) begin
          if (cnt == '0) begin
            res_found_next = 1'b0;
            res_code_next  = '0;
            res_idx_next   = '0;
            state_next     = S_FINISH;
          end else begin
            state_next = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        if (hit) begin
          res_found_next = 1'b1;
          res_code_next  = rd_entry.code;
          res_idx_next   = '0;
          state_next     = S_FINISH;
        end else begin
          raddr      = last_idx;
          state_next = S_LAST;
        end
      end
      S_LAST: begin
        if (hit) begin
          res_found_next = 1'b1;
          res_code_next  = rd_entry.code;
          res_idx_next   = last_idx;
          state_next     = S_FINISH;
        end else begin
          lo_next    = '0;
          hi_next    = last_idx;
          idx_next   = mid_of('0, last_idx);
          raddr      = idx_next;
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        if (hit) begin
          res_found_next = 1'b1;
          res_code_next  = rd_entry.code;
          res_idx_next   = idx;
          state_next     = S_FINISH;
        end else if (probe_mid == idx) begin
          // The bounds no longer move: the key is in no stored range.
          res_found_next = 1'b0;
          res_code_next  = '0;
          res_idx_next   = '0;
          state_next     = S_FINISH;
        end else begin
          lo_next  = probe_lo;
          hi_next  = probe_hi;
          idx_next = probe_mid;
          raddr    = probe_mid;
        end
      end
      S_FINISH: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (we) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_high <= item.addr_high;
      key_low  <= item.addr_low;
    end
    lo        <= lo_next;
    hi        <= hi_next;
    idx       <= idx_next;
    res_found <= res_found_next;
    res_code  <= res_code_next;
    res_idx   <= res_idx_next;
    if (out_load) begin
      out_found <= res_found;
      out_code  <= res_code;
      out_idx   <= res_idx;
    end
  end

  assign result.valid          = out_valid;
  assign result.found          = out_found;
  assign result.result_country = out_code;
  assign result.match_index    = MATCH_W'(out_idx);

endmodule

`default_nettype wire

// File: sv/arl_table.sv
`default_nettype none

module arl_table (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [arl_pkg::IDX_W-1:0] waddr,
  input  wire arl_pkg::entry_t          wdata,
  input  wire logic [arl_pkg::IDX_W-1:0] raddr,
  output arl_pkg::entry_t               rdata
);
  import arl_pkg::*;

  entry_t mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/arl_cmp.sv
`default_nettype none

module arl_cmp (
  input  wire logic [arl_pkg::ADDR_W-1:0] key_high,
  input  wire logic [arl_pkg::ADDR_W-1:0] key_low,
  input  wire arl_pkg::entry_t            entry,
  output arl_pkg::cmp_t                   cmp
);
  import arl_pkg::*;

  logic [2*ADDR_W-1:0] key;
  logic [2*ADDR_W-1:0] range_start;
  logic [2*ADDR_W-1:0] range_end;

  assign key         = {key_high, key_low};
  assign range_start = {entry.start_high, entry.start_low};
  assign range_end   = {entry.end_high, entry.end_low};

  assign cmp.lt_start = key < range_start;
  assign cmp.gt_end   = range_end < key;

endmodule

`default_nettype wire

// File: sv/arl_chk.sv
`default_nettype none

module arl_chk (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       in_action,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic                       out_found,
  input wire logic [arl_pkg::CODE_W-1:0]  out_country,
  input wire logic [arl_pkg::MATCH_W-1:0] out_index
);
  import arl_pkg::*;

  // A lookup word starts a search, so the item side must close at once.
  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_action |=> !in_ready)
    else $error("item ready stayed high after a lookup word");

  // An append word completes in its own cycle.
  a_append_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_action |=> in_ready)
    else $error("item ready dropped after an append word");

  // A miss carries no country code and no position.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_found |-> out_country == '0 && out_index == '0)
    else $error("miss word carries nonzero fields");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word withdrawn while stalled");

endmodule

bind address_range_lookup arl_chk u_arl_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (item.valid),
  .in_ready    (item.ready),
  .in_action   (item.action),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .out_found   (result.found),
  .out_country (result.result_country),
  .out_index   (result.match_index)
);

`default_nettype wire
